// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the framer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge, quiet while reset is asserted
`define EFB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// when cond holds, prop must hold in the next cycle
`define EFB_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hw/rtl/efb_pkg.sv =====
// types, constants and register codes of the escaped frame builder
package efb_pkg;

	localparam int unsigned FRAME_LIMIT = 128;
	localparam logic [7:0] LIMIT_LEN = 8'(FRAME_LIMIT);
	localparam logic [7:0] ROOM_LEN = 8'(FRAME_LIMIT - 2);

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// most frame bytes a single request can produce
	localparam int unsigned NBYTES = 6;
	localparam int unsigned CNT_W = $clog2(NBYTES + 1);

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_BEGIN   = 2'd0,
		OP_ADD     = 2'd1,
		OP_FINISH  = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BUSY = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ESC       = 3'd0,
		REG_ESC_ESC   = 3'd1,
		REG_DBL_ESC   = 3'd2,
		REG_START_PRI = 3'd3,
		REG_START_SEC = 3'd4,
		REG_END       = 3'd5
	} reg_idx_t;

	typedef enum logic {
		FS_ACCEPT  = 1'b0,
		FS_FIN_LOW = 1'b1
	} front_state_t;

	typedef struct packed {
		logic [7:0] esc_code;
		logic [7:0] esc_esc_code;
		logic [7:0] dbl_esc_code;
		logic [7:0] start_pri_code;
		logic [7:0] start_sec_code;
		logic [7:0] end_code;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		esc_code:       8'd27,
		esc_esc_code:   8'd30,
		dbl_esc_code:   8'd29,
		start_pri_code: 8'd2,
		start_sec_code: 8'd3,
		end_code:       8'd7
	};

	// everything one request turns into: frame bytes, then maybe a closing status item
	typedef struct packed {
		logic [NBYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]       cnt;
		logic                   tail;
		status_t                status;
	} desc_t;

	localparam desc_t DESC_EMPTY = '{bytes: '0, cnt: '0, tail: 1'b0, status: ST_OK};

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] data;
		status_t    status;
		logic       last;
	} result_t;

endpackage

// ===== hw/rtl/escaped_frame_builder_crc16_top.sv =====
// top level of the escaped frame builder with crc-16 ccitt
//
//   channel  dir  handshake         contents
//   s_*      in   s_tvalid/tready   op, data byte, kind select
//   m_*      out  m_tvalid/tready   out byte, status, byte flag, last
//   cfg_*    in   cfg_we            register index and value
//
// the front end takes one request per cycle while the queue has room; finish folds the crc high
// byte when accepted and the low byte in FS_FIN_LOW. each request yields 1 to 6 results and the
// output sends one per cycle while m_tready is high: an add with an escape pair yields 2
// a two-entry queue lets the front keep accepting while the output is stalled
// reset is asynchronous and clears all control state at once; no clearing pass
module escaped_frame_builder_crc16_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // op[1:0], data_byte[9:2], zero fill
	input  logic                          s_tuser,   // kind_select
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // out_byte[7:0], status[9:8], zero fill
	output logic                          m_tuser,   // byte_valid
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [efb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_wdata
);
	import efb_pkg::*;

	logic    q_push;
	desc_t   q_wdata;
	logic    q_full;
	logic    q_pop;
	logic    q_valid;
	desc_t   q_rdata;
	result_t res;

	efb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op_t'(s_tdata[1:0])),
		.in_data   (s_tdata[9:2]),
		.in_kind   (s_tuser),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	efb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	efb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {6'd0, res.status, res.data};
	assign m_tuser = res.byte_valid;
	assign m_tlast = res.last;

endmodule

// ===== hw/rtl/efb_front.sv =====
// front end: config registers, frame state, crc and escaping of each request
module efb_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [efb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  efb_pkg::op_t                  in_op,
	input  logic [7:0]                    in_data,
	input  logic                          in_kind,
	input  logic                          q_full,
	output logic                          q_push,
	output efb_pkg::desc_t                q_wdata
);
	import efb_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [1:0]  nb;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [15:0] crc;
		logic [7:0]  len;
		logic        held;
	} add_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic add_t add_fn(input cfg_t cfg, input logic [15:0] crc,
			input logic [7:0] len, input logic busy, input logic held, input logic [7:0] c);
		add_t r;
		r.status = ST_OK;
		r.nb     = 2'd0;
		r.b0     = '0;
		r.b1     = '0;
		r.crc    = crc;
		r.len    = len;
		r.held   = held;
		if (busy) begin
			r.status = ST_BUSY;
		end else if (len >= LIMIT_LEN) begin
			r.status = ST_FULL;
		end else if (c == cfg.esc_code) begin
			if (held) begin
				// second escape in a row rewrites the held code
				r.crc  = crc_fold(crc, c);
				r.nb   = 2'd1;
				r.b0   = cfg.dbl_esc_code;
				r.held = 1'b0;
			end else if (len > ROOM_LEN) begin
				r.status = ST_FULL;
			end else begin
				r.crc = crc_fold(crc, c);
				r.b0  = cfg.esc_code;
				if (len >= 8'd2) begin
					r.nb   = 2'd1;
					r.held = 1'b1;
				end else begin
					r.nb = 2'd2;
					r.b1 = cfg.esc_esc_code;
				end
				r.len = len + 8'd2;
			end
		end else begin
			r.crc = crc_fold(crc, c);
			if (held) begin
				r.nb   = 2'd2;
				r.b0   = cfg.esc_esc_code;
				r.b1   = c;
				r.held = 1'b0;
			end else begin
				r.nb = 2'd1;
				r.b0 = c;
			end
			r.len = len + 8'd1;
		end
		return r;
	endfunction

	function automatic desc_t put_byte(input desc_t d, input logic [7:0] b);
		desc_t r;
		r = d;
		if (r.cnt < CNT_W'(NBYTES)) begin
			r.bytes[r.cnt] = b;
			r.cnt          = r.cnt + CNT_W'(1);
		end
		return r;
	endfunction

	function automatic desc_t append(input desc_t d, input add_t a);
		desc_t r;
		r = d;
		if (a.nb != 2'd0) r = put_byte(r, a.b0);
		if (a.nb == 2'd2) r = put_byte(r, a.b1);
		return r;
	endfunction

	cfg_t         cfg_q;
	logic [15:0]  crc_q, crc_d;
	logic [7:0]   len_q, len_d;
	logic         busy_q, busy_d;
	logic         held_q, held_d;
	logic [7:0]   low_q, low_d;
	desc_t        part_q, part_d;
	front_state_t state_q, state_d;
	logic         acc;
	logic [7:0]   add_in;
	add_t         a;
	desc_t        d;

	assign acc = in_valid && in_ready;

	// one add unit: payload byte, crc high byte, then crc low byte in FS_FIN_LOW
	always_comb begin
		if (state_q == FS_FIN_LOW) add_in = low_q;
		else if (in_op == OP_FINISH) add_in = crc_q[15:8];
		else add_in = in_data;
	end

	assign a = add_fn(cfg_q, crc_q, len_q, busy_q, held_q, add_in);

	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_ACCEPT: begin
				if (acc && in_op == OP_FINISH && !busy_q) state_d = FS_FIN_LOW;
			end
			FS_FIN_LOW: begin
				if (!q_full) state_d = FS_ACCEPT;
			end
			default: state_d = FS_ACCEPT;
		endcase
	end

	always_comb begin
		in_ready = (state_q == FS_ACCEPT) && !q_full;
		crc_d    = crc_q;
		len_d    = len_q;
		busy_d   = busy_q;
		held_d   = held_q;
		low_d    = low_q;
		part_d   = part_q;
		d        = DESC_EMPTY;
		q_push   = 1'b0;
		if (state_q == FS_FIN_LOW) begin
			if (!q_full) begin
				d      = append(part_q, a);
				crc_d  = a.crc;
				len_d  = a.len;
				held_d = a.held;
				if (a.len <= ROOM_LEN) begin
					if (a.held) begin
						d      = put_byte(d, cfg_q.esc_esc_code);
						held_d = 1'b0;
					end
					d      = put_byte(d, cfg_q.esc_code);
					d      = put_byte(d, cfg_q.end_code);
					len_d  = a.len + 8'd2;
					busy_d = 1'b1;
				end else begin
					d.tail   = 1'b1;
					d.status = ST_FULL;
				end
				q_push = 1'b1;
			end
		end else if (acc) begin
			case (in_op)
				OP_BEGIN: begin
					if (busy_q) begin
						d.tail   = 1'b1;
						d.status = ST_BUSY;
					end else begin
						crc_d  = CRC_INIT;
						len_d  = 8'd2;
						held_d = 1'b0;
						d      = put_byte(d, cfg_q.esc_code);
						d      = put_byte(d, in_kind ? cfg_q.start_pri_code : cfg_q.start_sec_code);
					end
					q_push = 1'b1;
				end
				OP_ADD: begin
					d        = append(DESC_EMPTY, a);
					d.status = a.status;
					d.tail   = (a.status != ST_OK);
					crc_d    = a.crc;
					len_d    = a.len;
					held_d   = a.held;
					q_push   = 1'b1;
				end
				OP_FINISH: begin
					if (busy_q) begin
						d.tail   = 1'b1;
						d.status = ST_BUSY;
						q_push   = 1'b1;
					end else begin
						// high byte now, low byte (from the crc before this fold) in FS_FIN_LOW once the queue has room
						part_d = append(DESC_EMPTY, a);
						low_d  = crc_q[7:0];
						crc_d  = a.crc;
						len_d  = a.len;
						held_d = a.held;
					end
				end
				OP_RELEASE: begin
					busy_d = 1'b0;
					d.tail = 1'b1;
					q_push = 1'b1;
				end
				default: ;
			endcase
		end
		if (d.cnt == '0) d.tail = 1'b1;
		q_wdata = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= CFG_RESET;
			crc_q   <= CRC_INIT;
			len_q   <= '0;
			busy_q  <= 1'b0;
			held_q  <= 1'b0;
			state_q <= FS_ACCEPT;
		end else begin
			crc_q   <= crc_d;
			len_q   <= len_d;
			busy_q  <= busy_d;
			held_q  <= held_d;
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_ESC:       cfg_q.esc_code       <= cfg_wdata;
					REG_ESC_ESC:   cfg_q.esc_esc_code   <= cfg_wdata;
					REG_DBL_ESC:   cfg_q.dbl_esc_code   <= cfg_wdata;
					REG_START_PRI: cfg_q.start_pri_code <= cfg_wdata;
					REG_START_SEC: cfg_q.start_sec_code <= cfg_wdata;
					REG_END:       cfg_q.end_code       <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		low_q  <= low_d;
		part_q <= part_d;
	end

	`include "assert_macros.svh"

	`EFB_ASSERT(a_len_in_limit, len_q <= LIMIT_LEN, "frame length past limit")
	`EFB_ASSERT(a_held_after_start, held_q |-> (len_q >= 8'd4), "held code with no frame start")

endmodule

// ===== hw/rtl/efb_queue.sv =====
// short descriptor queue between the front end and the output sequencer
module efb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  efb_pkg::desc_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output efb_pkg::desc_t rdata
);
	import efb_pkg::*;

	desc_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	`include "assert_macros.svh"

	`EFB_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
	`EFB_ASSERT(a_no_underflow, pop |-> valid, "pop from empty queue")

endmodule

// ===== hw/rtl/efb_back.sv =====
// output sequencer: walks a descriptor and sends one result per cycle while out_ready is high
module efb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  efb_pkg::desc_t  q_rdata,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output efb_pkg::result_t out_res
);
	import efb_pkg::*;

	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	result_t          out_q;
	result_t          cur;
	logic             fin;
	logic             load;

	always_comb begin
		cur = '{byte_valid: 1'b0, data: '0, status: q_rdata.status, last: 1'b1};
		fin = 1'b1;
		if (idx_q < q_rdata.cnt) begin
			fin            = (idx_q == q_rdata.cnt - CNT_W'(1)) && !q_rdata.tail;
			cur.byte_valid = 1'b1;
			cur.data       = q_rdata.bytes[idx_q];
			cur.status     = ST_OK;
			cur.last       = fin;
		end
	end

	// output register refills in the cycle it is taken
	assign load  = q_valid && (!out_valid_q || out_ready);
	assign q_pop = load && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= fin ? '0 : idx_q + CNT_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= cur;
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	`include "assert_macros.svh"

	`EFB_ASSERT(a_head_held, (idx_q != '0) |-> q_valid, "descriptor left the queue mid-walk")
	`EFB_ASSERT_NEXT(a_pop_marks_last, q_pop, out_valid_q && out_q.last, "pop without a last result")

endmodule
